// ===== rtl/cbc_pkg.sv =====
// Cartridge bank controller package: sizes, address map, status codes and
// the decoded-access struct. No dependencies.
`default_nettype none
package cbc_pkg;

	localparam int RAM_BANKS      = 4;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int ROM_BANK_BITS  = 5;

	localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int RAM_OFF_W = $clog2(RAM_BANK_BYTES);
	localparam int ROM_AW    = 19;
	localparam int ROM_OFF_W = 14;

	localparam logic [15:0] ADDR_RAMEN_END  = 16'h2000;
	localparam logic [15:0] ADDR_ROMBANK_END = 16'h4000;
	localparam logic [15:0] ADDR_RAMBANK_END = 16'h6000;
	localparam logic [15:0] ADDR_VIDEO       = 16'h8000;
	localparam logic [15:0] ADDR_RAM         = 16'hA000;
	localparam logic [15:0] ADDR_HIGH        = 16'hC000;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] RAM_OFF_DATA   = 8'hFF;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_VIDEO = 2'd1,
		STATUS_HIGH  = 2'd2
	} status_t;

	typedef struct packed {
		logic    ram_read;
		logic    ram_write;
		logic    rom_read;
		logic    rom_banked;
		logic    set_ram_en;
		logic    set_rom_bank;
		logic    set_ram_bank;
		status_t status;
	} access_t;

endpackage
`default_nettype wire

// ===== rtl/cbc_decode.sv =====
// Address decode of one bus access into a set of access flags.
// Depends on cbc_pkg.
`default_nettype none
module cbc_decode (
	input  wire logic           command,
	input  wire logic [15:0]    address,
	output cbc_pkg::access_t    acc
);
	import cbc_pkg::*;

	logic is_wr;

	assign is_wr = (command == CMD_WRITE);

	always_comb begin
		acc = '0;
		acc.status = STATUS_OK;
		if (address >= ADDR_HIGH) begin
			acc.status = STATUS_HIGH;
		end else if (address >= ADDR_RAM) begin
			acc.ram_write = is_wr;
			acc.ram_read  = !is_wr;
		end else if (address >= ADDR_VIDEO) begin
			acc.status = STATUS_VIDEO;
		end else if (is_wr) begin
			acc.set_ram_en   = (address < ADDR_RAMEN_END);
			acc.set_rom_bank = (address >= ADDR_RAMEN_END) && (address < ADDR_ROMBANK_END);
			acc.set_ram_bank = (address >= ADDR_ROMBANK_END) && (address < ADDR_RAMBANK_END);
		end else begin
			acc.rom_read   = 1'b1;
			acc.rom_banked = (address >= ADDR_ROMBANK_END);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cbc_bank_regs.sv =====
// RAM enable flag and ROM/RAM bank registers, updated by control writes.
// Depends on cbc_pkg.
`default_nettype none
module cbc_bank_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             valid,
	input  wire cbc_pkg::access_t                 acc,
	input  wire logic [7:0]                       data,
	output logic                                  ram_en,
	output logic [cbc_pkg::ROM_BANK_BITS-1:0]     rom_bank,
	output logic [1:0]                            ram_bank
);
	import cbc_pkg::*;

	logic                     ram_en_q;
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [1:0]               ram_bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q   <= 1'b0;
			rom_bank_q <= '0;
			ram_bank_q <= '0;
		end else if (valid) begin
			if (acc.set_ram_en)
				ram_en_q <= (data[3:0] == RAM_ENABLE_KEY);
			if (acc.set_rom_bank)
				rom_bank_q <= data[ROM_BANK_BITS-1:0];
			if (acc.set_ram_bank)
				ram_bank_q <= data[1:0];
		end
	end

	assign ram_en   = ram_en_q;
	assign rom_bank = rom_bank_q;
	assign ram_bank = ram_bank_q;

endmodule
`default_nettype wire

// ===== rtl/cbc_cart_ram.sv =====
// Banked cartridge RAM: one synchronous port, registered read data.
// Depends on cbc_pkg.
`default_nettype none
module cbc_cart_ram (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic                        rd_en,
	input  wire logic [cbc_pkg::RAM_AW-1:0]  addr,
	input  wire logic [7:0]                  wdata,
	output logic [7:0]                       rdata
);
	import cbc_pkg::*;

	logic [7:0] mem [RAM_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= wdata;
		if (rd_en)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/cartridge_bank_controller.sv =====
// Cartridge bank controller top level: input register, decode, bank
// registers, cart RAM and result register. Depends on cbc_pkg and submodules.
// Results: an access passes the input register, then the result register;
// done and the result are registered and presented together.
// Throughput: one transfer per cycle; busy is always low, set by the single
// RAM port and the bank registers being read and updated in stage one.
// Reset: asynchronous, clears bank registers, enable flag and valid flags;
// cart RAM contents are undefined until written. Results cannot be stalled.
`default_nettype none
module cartridge_bank_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          command,
	input  wire logic [15:0]   address,
	input  wire logic [7:0]    write_data,
	output logic               done,
	output logic [7:0]         read_data,
	output logic               rom_fetch,
	output logic [18:0]        rom_address,
	output logic [1:0]         status
);
	import cbc_pkg::*;

	logic        valid_s1;
	logic        command_s1;
	logic [15:0] address_s1;
	logic [7:0]  wdata_s1;

	access_t                  acc;
	logic                     ram_en;
	logic [ROM_BANK_BITS-1:0] rom_bank;
	logic [1:0]               ram_bank;
	logic [ROM_BANK_BITS-1:0] mapped_bank;
	logic [2:0]               bank_mod;
	logic [RAM_AW-1:0]        ram_addr;
	logic [RAM_OFF_W-1:0]     ram_off;
	logic [15:0]              ram_rel;
	logic [7:0]               ram_rdata;
	logic [18:0]              rom_addr_c;

	logic        valid_s2;
	logic        ram_rd_s2;
	logic [7:0]  data_s2;
	logic        fetch_s2;
	logic [18:0] rom_addr_s2;
	status_t     status_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			command_s1 <= command;
			address_s1 <= address;
			wdata_s1   <= write_data;
		end
	end

	cbc_decode u_decode (
		.command (command_s1),
		.address (address_s1),
		.acc     (acc)
	);

	cbc_bank_regs u_bank_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s1),
		.acc      (acc),
		.data     (wdata_s1),
		.ram_en   (ram_en),
		.rom_bank (rom_bank),
		.ram_bank (ram_bank)
	);

	// bank zero (low five bits) maps to bank one
	assign mapped_bank = rom_bank | ROM_BANK_BITS'(rom_bank[4:0] == 5'd0);
	assign rom_addr_c  = !acc.rom_read   ? 19'd0 :
	                     acc.rom_banked  ? ROM_AW'({mapped_bank, address_s1[ROM_OFF_W-1:0]}) :
	                                       ROM_AW'(address_s1);

	assign bank_mod = 3'({1'b0, ram_bank} % 3'(RAM_BANKS));
	assign ram_rel  = address_s1 - ADDR_RAM;
	assign ram_off  = ram_rel[RAM_OFF_W-1:0];
	assign ram_addr = RAM_AW'({bank_mod, ram_off});

	cbc_cart_ram u_cart_ram (
		.clk   (clk),
		.wr_en (valid_s1 && acc.ram_write && ram_en),
		.rd_en (valid_s1 && acc.ram_read && ram_en),
		.addr  (ram_addr),
		.wdata (wdata_s1),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ram_rd_s2   <= acc.ram_read && ram_en;
			data_s2     <= (acc.ram_read && !ram_en) ? RAM_OFF_DATA : 8'd0;
			fetch_s2    <= acc.rom_read;
			rom_addr_s2 <= rom_addr_c;
			status_s2   <= acc.status;
		end
	end

	assign done        = valid_s2;
	assign read_data   = ram_rd_s2 ? ram_rdata : data_s2;
	assign rom_fetch   = fetch_s2;
	assign rom_address = rom_addr_s2;
	assign status      = status_s2;

endmodule
`default_nettype wire
